/* rtl/core/tbcr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-body collision response: shared definitions
// Widths, fixed-point constants, the queue transaction format and the
// saturation helper used by the front and back halves of the datapath.
// ----------------------------------------------------------------------------
package tbcr_pkg;

    // Fixed-point formats of the normal and the restitution coefficients.
    localparam int NORM_BITS = 14;
    localparam int REST_BITS = 15;
    localparam logic [15:0] REST_ONE = 16'd32768;

    // Stream widths.
    localparam int S_DATA_W = 272;
    localparam int M_DATA_W = 256;

    // Divider: quotient bits (one stage per bit), numerator and divisor widths.
    localparam int QUOT_W = 32;
    localparam int DEN_W  = 25;
    localparam int NUM_W  = QUOT_W + DEN_W;

    // Queue depth and pointer width.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;

    // Back-end datapath widths.
    localparam int W_W    = 34;   // relative velocity component
    localparam int N_W    = 17;   // normal component, negation included
    localparam int DOT_W  = 52;   // dot product
    localparam int PROD_W = 51;   // velocity times normal
    localparam int DN_W   = 38;   // dot product after the normal scaling
    localparam int J_W    = 56;   // impulse before the restitution scaling
    localparam int JJ_W   = 41;   // impulse after the restitution scaling
    localparam int JN_W   = 58;   // impulse times normal
    localparam int MP_W   = 49;   // share times normal
    localparam int MV_W   = 35;   // position correction before saturation
    localparam int WIDE_W = 46;   // final sum before saturation

    // How a contact is treated.
    typedef enum logic [1:0] {
        MODE_PAIR,
        MODE_A,
        MODE_B
    } mode_t;

    // One classified contact as it travels through the queue.
    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] a_vx;
        logic signed [31:0] a_vy;
        logic signed [31:0] b_vx;
        logic signed [31:0] b_vy;
        logic signed [31:0] cm_x;
        logic signed [31:0] cm_y;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [30:0]        share_a;
        logic [30:0]        share_b;
        logic [15:0]        rest;
    } item_t;

    // Saturate a wide signed value to 32-bit signed.
    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic [WIDE_W-32:0] top;
        top = x[WIDE_W-1:31];
        if (top == '0 || top == '1) begin
            return x[31:0];
        end
        return x[WIDE_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

endpackage

/* rtl/core/tbcr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-body collision response: pipelined divider
// Unsigned restoring division, one quotient bit per stage. The numerator
// must be below the divisor times two to the quotient width.
// ----------------------------------------------------------------------------
module tbcr_div
    import tbcr_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num_i,
    input  logic [DEN_W-1:0]  den_i,
    output logic [QUOT_W-1:0] quot_o,
    output logic              rem_nz_o
);

    logic [DEN_W-1:0]  rem_reg [QUOT_W];
    logic [QUOT_W-1:0] nq_reg  [QUOT_W];
    logic [DEN_W-1:0]  den_reg [QUOT_W];
    logic [NUM_W-1:0]  step_next [QUOT_W];

    // One restoring step: bring down a numerator bit, subtract if it fits.
    function automatic logic [NUM_W-1:0] div_step(input logic [DEN_W-1:0] r,
                                                  input logic [QUOT_W-1:0] nq,
                                                  input logic [DEN_W-1:0] d);
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        logic           q;
        t    = {r, nq[QUOT_W-1]};
        diff = t - {1'b0, d};
        q    = (t >= {1'b0, d});
        return {q ? diff[DEN_W-1:0] : t[DEN_W-1:0], nq[QUOT_W-2:0], q};
    endfunction

    // Step logic of every stage.
    always_comb begin
        step_next[0] = div_step(num_i[NUM_W-1:QUOT_W], num_i[QUOT_W-1:0], den_i);
        for (int k = 1; k < QUOT_W; k++) begin
            step_next[k] = div_step(rem_reg[k-1], nq_reg[k-1], den_reg[k-1]);
        end
    end

    // Stage registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QUOT_W; k++) begin
                rem_reg[k] <= step_next[k][NUM_W-1:QUOT_W];
                nq_reg[k]  <= step_next[k][QUOT_W-1:0];
                den_reg[k] <= (k == 0) ? den_i : den_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign quot_o   = nq_reg[QUOT_W-1];
    assign rem_nz_o = (rem_reg[QUOT_W-1] != '0);

endmodule

/* rtl/core/tbcr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-body collision response: front end
// Accepts contacts, classifies them, and works out the centre-of-mass
// velocity and the overlap shares through three pipelined dividers.
// ----------------------------------------------------------------------------
module tbcr_front
    import tbcr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [S_DATA_W-1:0] in_data,
    input  logic [1:0]          in_mask,
    output logic                out_valid,
    input  logic                out_ready,
    output item_t               out_item
);

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] a_vx;
        logic signed [31:0] a_vy;
        logic signed [31:0] b_vx;
        logic signed [31:0] b_vy;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [30:0]        ov;
        logic [15:0]        rest;
    } side_t;

    typedef struct packed {
        side_t side;
        logic  neg_x;
        logic  neg_y;
    } dly_t;

    logic               en;

    side_t              s0_side_next;
    logic [23:0]        s0_am_next;
    logic [23:0]        s0_bm_next;
    logic               s0_valid_reg;
    side_t              s0_side_reg;
    logic [23:0]        s0_am_reg;
    logic [23:0]        s0_bm_reg;

    logic               s1_valid_reg;
    side_t              s1_side_reg;
    logic signed [56:0] s1_px_a_reg;
    logic signed [56:0] s1_px_b_reg;
    logic signed [56:0] s1_py_a_reg;
    logic signed [56:0] s1_py_b_reg;
    logic [54:0]        s1_ova_reg;
    logic [DEN_W-1:0]   s1_msum_reg;

    logic signed [57:0] sum_x;
    logic signed [57:0] sum_y;
    logic signed [57:0] mag_x;
    logic signed [57:0] mag_y;

    logic               s2_valid_reg;
    side_t              s2_side_reg;
    logic [NUM_W-1:0]   s2_num_x_reg;
    logic [NUM_W-1:0]   s2_num_y_reg;
    logic [NUM_W-1:0]   s2_num_a_reg;
    logic               s2_neg_x_reg;
    logic               s2_neg_y_reg;
    logic [DEN_W-1:0]   s2_den_reg;

    logic [QUOT_W-1:0]  line_valid_reg;
    dly_t               line_reg [QUOT_W];

    logic [QUOT_W-1:0]  quot_x;
    logic [QUOT_W-1:0]  quot_y;
    logic [QUOT_W-1:0]  quot_a;
    logic               rem_nz_x;
    logic               rem_nz_y;
    logic               rem_nz_a;

    dly_t               last;
    logic [30:0]        sa;
    logic [31:0]        cm_x;
    logic [31:0]        cm_y;

    // The whole front pipeline moves unless its last stage is held.
    assign en       = !line_valid_reg[QUOT_W-1] || out_ready;
    assign in_ready = en;

    // Unpack, clamp and classify the incoming transaction.
    always_comb begin
        logic [15:0] ea;
        logic [15:0] eb;
        ea = (in_data[254:239] > REST_ONE) ? REST_ONE : in_data[254:239];
        eb = (in_data[270:255] > REST_ONE) ? REST_ONE : in_data[270:255];
        s0_side_next.a_vx = in_data[31:0];
        s0_side_next.a_vy = in_data[63:32];
        s0_side_next.b_vx = in_data[119:88];
        s0_side_next.b_vy = in_data[151:120];
        s0_side_next.nx   = in_data[191:176];
        s0_side_next.ny   = in_data[207:192];
        s0_side_next.ov   = in_data[238:208];
        if (in_mask == 2'b11) begin
            s0_side_next.mode = MODE_PAIR;
            s0_side_next.rest = eb;
        end else if (in_mask[0]) begin
            s0_side_next.mode = MODE_A;
            s0_side_next.rest = ea;
        end else begin
            s0_side_next.mode = MODE_B;
            s0_side_next.rest = ea;
        end
        s0_am_next = (in_data[87:64] == '0) ? 24'd1 : in_data[87:64];
        s0_bm_next = (in_data[175:152] == '0) ? 24'd1 : in_data[175:152];
    end

    // Signed momentum sums and their magnitudes for the dividers.
    always_comb begin
        sum_x = 58'(s1_px_a_reg) + 58'(s1_px_b_reg);
        sum_y = 58'(s1_py_a_reg) + 58'(s1_py_b_reg);
        mag_x = sum_x[57] ? -sum_x : sum_x;
        mag_y = sum_y[57] ? -sum_y : sum_y;
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            line_valid_reg <= '0;
        end else if (en) begin
            s0_valid_reg   <= in_valid;
            s1_valid_reg   <= s0_valid_reg;
            s2_valid_reg   <= s1_valid_reg;
            line_valid_reg <= {line_valid_reg[QUOT_W-2:0], s2_valid_reg};
        end
    end

    // Payload stages: input, products, divider operands, delay line.
    always_ff @(posedge aclk) begin
        if (en) begin
            s0_side_reg  <= s0_side_next;
            s0_am_reg    <= s0_am_next;
            s0_bm_reg    <= s0_bm_next;

            s1_side_reg  <= s0_side_reg;
            s1_px_a_reg  <= $signed({1'b0, s0_am_reg}) * s0_side_reg.a_vx;
            s1_px_b_reg  <= $signed({1'b0, s0_bm_reg}) * s0_side_reg.b_vx;
            s1_py_a_reg  <= $signed({1'b0, s0_am_reg}) * s0_side_reg.a_vy;
            s1_py_b_reg  <= $signed({1'b0, s0_bm_reg}) * s0_side_reg.b_vy;
            s1_ova_reg   <= s0_side_reg.ov * s0_bm_reg;
            s1_msum_reg  <= {1'b0, s0_am_reg} + {1'b0, s0_bm_reg};

            s2_side_reg  <= s1_side_reg;
            s2_num_x_reg <= mag_x[NUM_W-1:0];
            s2_num_y_reg <= mag_y[NUM_W-1:0];
            s2_num_a_reg <= {2'b00, s1_ova_reg};
            s2_neg_x_reg <= sum_x[57];
            s2_neg_y_reg <= sum_y[57];
            s2_den_reg   <= s1_msum_reg;

            line_reg[0]  <= '{side: s2_side_reg, neg_x: s2_neg_x_reg,
                              neg_y: s2_neg_y_reg};
            for (int k = 1; k < QUOT_W; k++) begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    tbcr_div u_div_x (
        .aclk     (aclk),
        .en       (en),
        .num_i    (s2_num_x_reg),
        .den_i    (s2_den_reg),
        .quot_o   (quot_x),
        .rem_nz_o (rem_nz_x)
    );

    tbcr_div u_div_y (
        .aclk     (aclk),
        .en       (en),
        .num_i    (s2_num_y_reg),
        .den_i    (s2_den_reg),
        .quot_o   (quot_y),
        .rem_nz_o (rem_nz_y)
    );

    tbcr_div u_div_a (
        .aclk     (aclk),
        .en       (en),
        .num_i    (s2_num_a_reg),
        .den_i    (s2_den_reg),
        .quot_o   (quot_a),
        .rem_nz_o (rem_nz_a)
    );

    // Restore signs and build the queue transaction. Only the pair case uses
    // the quotients; B's share is the overlap less the rounded-up A share.
    always_comb begin
        last = line_reg[QUOT_W-1];
        sa   = quot_a[30:0];
        cm_x = last.neg_x ? (32'd0 - quot_x) : quot_x;
        cm_y = last.neg_y ? (32'd0 - quot_y) : quot_y;

        out_item.mode = last.side.mode;
        out_item.a_vx = last.side.a_vx;
        out_item.a_vy = last.side.a_vy;
        out_item.b_vx = last.side.b_vx;
        out_item.b_vy = last.side.b_vy;
        out_item.nx   = last.side.nx;
        out_item.ny   = last.side.ny;
        out_item.rest = last.side.rest;
        unique case (last.side.mode)
            MODE_PAIR: begin
                out_item.cm_x    = cm_x;
                out_item.cm_y    = cm_y;
                out_item.share_a = sa;
                out_item.share_b = last.side.ov - sa - 31'(rem_nz_a);
            end
            MODE_A: begin
                out_item.cm_x    = '0;
                out_item.cm_y    = '0;
                out_item.share_a = last.side.ov;
                out_item.share_b = '0;
            end
            default: begin
                out_item.cm_x    = '0;
                out_item.cm_y    = '0;
                out_item.share_a = '0;
                out_item.share_b = last.side.ov;
            end
        endcase
    end

    assign out_valid = line_valid_reg[QUOT_W-1];

    // The velocity quotients never leave a remainder that matters.
    logic unused_rem;
    assign unused_rem = rem_nz_x ^ rem_nz_y;

endmodule

/* rtl/core/tbcr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-body collision response: decoupling queue
// A short first-in first-out queue of classified contacts between the front
// and back ends.
// ----------------------------------------------------------------------------
module tbcr_fifo
    import tbcr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t wdata,
    output logic  full,
    input  logic  pop,
    output item_t rdata,
    output logic  empty
);

    item_t            mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full  = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/core/tbcr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-body collision response: back end
// Reflects the relative velocities about the contact normal, applies the
// restitution and the position corrections, and saturates the results.
// ----------------------------------------------------------------------------
module tbcr_back
    import tbcr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  item_t               in_item,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [M_DATA_W-1:0] m_data
);

    typedef struct packed {
        logic signed [W_W-1:0] w_x;
        logic signed [W_W-1:0] w_y;
        logic signed [N_W-1:0] n_x;
        logic signed [N_W-1:0] n_y;
    } lane_t;

    typedef struct packed {
        lane_t              la;
        lane_t              lb;
        logic signed [31:0] cm_x;
        logic signed [31:0] cm_y;
        logic [16:0]        e1;
        mode_t              mode;
    } ctx_t;

    typedef struct packed {
        logic signed [MV_W-1:0] ax;
        logic signed [MV_W-1:0] ay;
        logic signed [MV_W-1:0] bx;
        logic signed [MV_W-1:0] by;
    } mv_t;

    logic                    en;
    logic [6:0]              valid_reg;

    ctx_t                    st1_ctx_next;
    ctx_t                    st1_ctx_reg;
    logic [30:0]             st1_sha_reg;
    logic [30:0]             st1_shb_reg;

    ctx_t                    st2_ctx_reg;
    logic signed [PROD_W-1:0] st2_pax_reg, st2_pay_reg, st2_pbx_reg, st2_pby_reg;
    logic signed [MP_W-1:0]  st2_max_reg, st2_may_reg, st2_mbx_reg, st2_mby_reg;

    ctx_t                    st3_ctx_reg;
    logic signed [DOT_W-1:0] st3_da_reg;
    logic signed [DOT_W-1:0] st3_db_reg;
    mv_t                     st3_mv_reg;

    ctx_t                    st4_ctx_reg;
    logic                    st4_ref_a_reg;
    logic                    st4_ref_b_reg;
    logic signed [DN_W-1:0]  st4_dna_reg;
    logic signed [DN_W-1:0]  st4_dnb_reg;
    mv_t                     st4_mv_reg;
    logic                    ref_a_next;
    logic                    ref_b_next;

    ctx_t                    st5_ctx_reg;
    logic                    st5_ref_a_reg;
    logic                    st5_ref_b_reg;
    logic signed [J_W-1:0]   st5_ja_reg;
    logic signed [J_W-1:0]   st5_jb_reg;
    mv_t                     st5_mv_reg;

    ctx_t                    st6_ctx_reg;
    logic                    st6_ref_a_reg;
    logic                    st6_ref_b_reg;
    logic signed [JN_W-1:0]  st6_jnax_reg, st6_jnay_reg, st6_jnbx_reg, st6_jnby_reg;
    mv_t                     st6_mv_reg;
    logic signed [JJ_W-1:0]  jja;
    logic signed [JJ_W-1:0]  jjb;

    logic [M_DATA_W-1:0]     out_next;
    logic [M_DATA_W-1:0]     out_reg;

    // The back pipeline moves when its output register is free or taken.
    assign en      = !valid_reg[6] || m_ready;
    assign pop     = en && in_valid;
    assign m_valid = valid_reg[6];
    assign m_data  = out_reg;

    // Velocities relative to the centre of mass and the normal of each body.
    always_comb begin
        st1_ctx_next.la.w_x = W_W'(in_item.a_vx) - W_W'(in_item.cm_x);
        st1_ctx_next.la.w_y = W_W'(in_item.a_vy) - W_W'(in_item.cm_y);
        st1_ctx_next.lb.w_x = W_W'(in_item.b_vx) - W_W'(in_item.cm_x);
        st1_ctx_next.lb.w_y = W_W'(in_item.b_vy) - W_W'(in_item.cm_y);
        st1_ctx_next.la.n_x = N_W'(in_item.nx);
        st1_ctx_next.la.n_y = N_W'(in_item.ny);
        st1_ctx_next.lb.n_x = -N_W'(in_item.nx);
        st1_ctx_next.lb.n_y = -N_W'(in_item.ny);
        st1_ctx_next.cm_x   = in_item.cm_x;
        st1_ctx_next.cm_y   = in_item.cm_y;
        st1_ctx_next.e1     = 17'(in_item.rest) + 17'(REST_ONE);
        st1_ctx_next.mode   = in_item.mode;
    end

    // Which bodies bounce: both must approach in the pair case.
    always_comb begin
        unique case (st3_ctx_reg.mode)
            MODE_PAIR: begin
                ref_a_next = st3_da_reg[DOT_W-1] && st3_db_reg[DOT_W-1];
                ref_b_next = ref_a_next;
            end
            MODE_A: begin
                ref_a_next = st3_da_reg[DOT_W-1];
                ref_b_next = 1'b0;
            end
            default: begin
                ref_a_next = 1'b0;
                ref_b_next = st3_db_reg[DOT_W-1];
            end
        endcase
    end

    // Impulse after the restitution scaling.
    assign jja = JJ_W'(st5_ja_reg >>> REST_BITS);
    assign jjb = JJ_W'(st5_jb_reg >>> REST_BITS);

    // Final velocities and corrections, saturated and packed.
    always_comb begin
        logic signed [WIDE_W-1:0] cax, cay, cbx, cby;
        logic signed [WIDE_W-1:0] rax, ray, rbx, rby;
        cax = st6_ref_a_reg ? WIDE_W'(st6_jnax_reg >>> NORM_BITS) : '0;
        cay = st6_ref_a_reg ? WIDE_W'(st6_jnay_reg >>> NORM_BITS) : '0;
        cbx = st6_ref_b_reg ? WIDE_W'(st6_jnbx_reg >>> NORM_BITS) : '0;
        cby = st6_ref_b_reg ? WIDE_W'(st6_jnby_reg >>> NORM_BITS) : '0;
        rax = WIDE_W'(st6_ctx_reg.la.w_x) - cax + WIDE_W'(st6_ctx_reg.cm_x);
        ray = WIDE_W'(st6_ctx_reg.la.w_y) - cay + WIDE_W'(st6_ctx_reg.cm_y);
        rbx = WIDE_W'(st6_ctx_reg.lb.w_x) - cbx + WIDE_W'(st6_ctx_reg.cm_x);
        rby = WIDE_W'(st6_ctx_reg.lb.w_y) - cby + WIDE_W'(st6_ctx_reg.cm_y);
        out_next = {sat32(WIDE_W'(st6_mv_reg.by)), sat32(WIDE_W'(st6_mv_reg.bx)),
                    sat32(WIDE_W'(st6_mv_reg.ay)), sat32(WIDE_W'(st6_mv_reg.ax)),
                    sat32(rby), sat32(rbx), sat32(ray), sat32(rax)};
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            st1_ctx_reg   <= st1_ctx_next;
            st1_sha_reg   <= in_item.share_a;
            st1_shb_reg   <= in_item.share_b;

            st2_ctx_reg   <= st1_ctx_reg;
            st2_pax_reg   <= st1_ctx_reg.la.w_x * st1_ctx_reg.la.n_x;
            st2_pay_reg   <= st1_ctx_reg.la.w_y * st1_ctx_reg.la.n_y;
            st2_pbx_reg   <= st1_ctx_reg.lb.w_x * st1_ctx_reg.lb.n_x;
            st2_pby_reg   <= st1_ctx_reg.lb.w_y * st1_ctx_reg.lb.n_y;
            st2_max_reg   <= $signed({1'b0, st1_sha_reg}) * st1_ctx_reg.la.n_x;
            st2_may_reg   <= $signed({1'b0, st1_sha_reg}) * st1_ctx_reg.la.n_y;
            st2_mbx_reg   <= $signed({1'b0, st1_shb_reg}) * st1_ctx_reg.lb.n_x;
            st2_mby_reg   <= $signed({1'b0, st1_shb_reg}) * st1_ctx_reg.lb.n_y;

            st3_ctx_reg   <= st2_ctx_reg;
            st3_da_reg    <= DOT_W'(st2_pax_reg) + DOT_W'(st2_pay_reg);
            st3_db_reg    <= DOT_W'(st2_pbx_reg) + DOT_W'(st2_pby_reg);
            st3_mv_reg.ax <= MV_W'(st2_max_reg >>> NORM_BITS);
            st3_mv_reg.ay <= MV_W'(st2_may_reg >>> NORM_BITS);
            st3_mv_reg.bx <= MV_W'(st2_mbx_reg >>> NORM_BITS);
            st3_mv_reg.by <= MV_W'(st2_mby_reg >>> NORM_BITS);

            st4_ctx_reg   <= st3_ctx_reg;
            st4_ref_a_reg <= ref_a_next;
            st4_ref_b_reg <= ref_b_next;
            st4_dna_reg   <= DN_W'(st3_da_reg >>> NORM_BITS);
            st4_dnb_reg   <= DN_W'(st3_db_reg >>> NORM_BITS);
            st4_mv_reg    <= st3_mv_reg;

            st5_ctx_reg   <= st4_ctx_reg;
            st5_ref_a_reg <= st4_ref_a_reg;
            st5_ref_b_reg <= st4_ref_b_reg;
            st5_ja_reg    <= st4_dna_reg * $signed({1'b0, st4_ctx_reg.e1});
            st5_jb_reg    <= st4_dnb_reg * $signed({1'b0, st4_ctx_reg.e1});
            st5_mv_reg    <= st4_mv_reg;

            st6_ctx_reg   <= st5_ctx_reg;
            st6_ref_a_reg <= st5_ref_a_reg;
            st6_ref_b_reg <= st5_ref_b_reg;
            st6_jnax_reg  <= jja * st5_ctx_reg.la.n_x;
            st6_jnay_reg  <= jja * st5_ctx_reg.la.n_y;
            st6_jnbx_reg  <= jjb * st5_ctx_reg.lb.n_x;
            st6_jnby_reg  <= jjb * st5_ctx_reg.lb.n_y;
            st6_mv_reg    <= st5_mv_reg;

            out_reg       <= out_next;
        end
    end

endmodule

/* rtl/core/two_body_collision_response.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-body collision response
// Impulse response with restitution for one contact between two bodies,
// in Q16.16 fixed point with saturated results.
// ----------------------------------------------------------------------------
// The block takes one contact transaction per clock cycle while the output
// is not held, and returns one result transaction per contact, in order.
// The front end registers the input, the products and the divider operands
// and feeds the 32-stage radix-2 dividers that form the centre-of-mass
// velocity and the overlap shares; the four-entry queue follows, then the
// back end, which holds the multipliers of the reflection.
// The queue lets the front end keep accepting contacts for a short while
// when the output is held.
module two_body_collision_response
    import tbcr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // a_vel_x, a_vel_y, a_mass, b_vel_x, b_vel_y, b_mass, normal_x, normal_y,
    // overlap, rest_a, rest_b (one zero pad bit at the top)
    input  logic [S_DATA_W-1:0] s_tdata,
    // free_mask
    input  logic [1:0]          s_tuser,
    input  logic                s_tvalid,
    output logic                s_tready,
    // a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y,
    // a_move_x, a_move_y, b_move_x, b_move_y
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready
);

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    item_t q_wdata;
    item_t q_rdata;

    // Front end: classification and division.
    tbcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .in_mask   (s_tuser),
        .out_valid (q_push),
        .out_ready (!q_full),
        .out_item  (q_wdata)
    );

    // Queue between the two halves.
    tbcr_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push && !q_full),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    // Back end: reflection and output register.
    tbcr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (!q_empty),
        .in_item  (q_rdata),
        .pop      (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_tdata)
    );

endmodule
